// ===== src/lseg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lseg_pkg
// Shared types and constants of the LED strip effect generator.
// ----------------------------------------------------------------------------
package lseg_pkg;

	localparam int MAX_PIXELS_DEF  = 64;
	localparam int QUEUE_DEPTH_DEF = 2;

	// Effect mode codes
	localparam logic [1:0] MODE_SOLID = 2'd0;
	localparam logic [1:0] MODE_SCAN  = 2'd1;
	localparam logic [1:0] MODE_BLINK = 2'd2;
	localparam logic [1:0] MODE_RSVD  = 2'd3;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_EFFECT_MODE    = 2'd0,
		CFG_MAIN_COLOR     = 2'd1,
		CFG_FRAME_INTERVAL = 2'd2,
		CFG_PIXEL_COUNT    = 2'd3
	} cfg_index_t;

	localparam int CNT_W = 7;   // strip length 1..64 plus headroom
	localparam int IDX_W = 6;   // pixel_index field width

	localparam logic [16:0] ELAPSED_MAX  = 17'h1FFFF;
	localparam logic [6:0]  SCAN_STEPS   = 7'd70;
	localparam logic [7:0]  SCAN_PERIOD  = 8'd140;
	localparam logic [7:0]  BLINK_PERIOD = 8'd100;
	localparam logic [7:0]  BLINK_HALF   = 8'd50;
	localparam logic [12:0] FALLOFF      = 13'd500;
	// floor(u / 125) == (u * RECIP) >> RECIP_SHIFT for u < 59074
	localparam logic [15:0] RECIP        = 16'd33555;
	localparam int          RECIP_SHIFT  = 22;

	localparam logic [23:0] COLOR_RESET    = 24'hFFFF00;
	localparam logic [15:0] INTERVAL_RESET = 16'd20;
	localparam logic [6:0]  COUNT_RESET    = 7'd64;

	// Side effects of a configuration write on the timing state
	typedef struct packed {
		logic clear_counter;
		logic set_refresh;
	} cfg_evt_t;

	// One frame request from the front to the back
	typedef struct packed {
		logic       scan;     // scanner falloff shape
		logic       lit;      // flat frame shows main_color, else black
		logic [6:0] step;     // scanner head position 0..70
	} job_t;

endpackage

// ===== src/lseg_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lseg_front
// Tick timing, refresh tracking and effect counter; issues frame requests.
// ----------------------------------------------------------------------------
module lseg_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tick_valid,
	output logic              tick_ready,
	input  logic              tick,
	input  logic [1:0]        mode,
	input  logic [15:0]       interval,
	input  lseg_pkg::cfg_evt_t cfg_evt,
	input  logic              queue_full,
	output logic              push,
	output lseg_pkg::job_t    job
);
	import lseg_pkg::*;

	logic [16:0] elapsed_q;
	logic [7:0]  counter_q;
	logic        refresh_q;

	logic        take;
	logic [16:0] el_inc;
	logic        fire;
	logic        pend;
	logic [7:0]  cnt_scan;
	logic [7:0]  cnt_blink;
	logic [7:0]  cnt_next;

	assign tick_ready = !queue_full;
	assign take       = tick_valid && tick_ready && tick;

	always_comb begin
		el_inc    = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 17'd1;
		fire      = (mode != MODE_SOLID) && (el_inc > {1'b0, interval});
		pend      = refresh_q || fire;
		cnt_scan  = (counter_q >= SCAN_PERIOD) ? counter_q - SCAN_PERIOD : counter_q;
		if (counter_q >= 8'd200) begin
			cnt_blink = counter_q - 8'd200;
		end else if (counter_q >= BLINK_PERIOD) begin
			cnt_blink = counter_q - BLINK_PERIOD;
		end else begin
			cnt_blink = counter_q;
		end
		job      = '0;
		cnt_next = counter_q;
		case (mode)
			MODE_SOLID: begin
				job.lit = 1'b1;
			end
			MODE_SCAN: begin
				job.scan = 1'b1;
				job.step = (cnt_scan > {1'b0, SCAN_STEPS}) ? 7'(SCAN_PERIOD - cnt_scan)
				                                             : cnt_scan[6:0];
				cnt_next = cnt_scan + 8'd1;
			end
			MODE_BLINK: begin
				job.lit  = (cnt_blink > BLINK_HALF);
				cnt_next = cnt_blink + 8'd1;
			end
			default: begin
				job = '0;
			end
		endcase
		push = take && pend && (mode != MODE_RSVD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			counter_q <= '0;
			refresh_q <= 1'b1;
		end else begin
			if (take) begin
				elapsed_q <= fire ? 17'd0 : el_inc;
				if (pend) begin
					refresh_q <= 1'b0;
					counter_q <= cnt_next;
				end
			end
			if (cfg_evt.clear_counter) begin
				counter_q <= '0;
			end
			if (cfg_evt.set_refresh) begin
				refresh_q <= 1'b1;
			end
		end
	end

endmodule

// ===== src/lseg_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lseg_queue
// Small FIFO of frame requests between front and back.
// ----------------------------------------------------------------------------
module lseg_queue #(
	parameter int DEPTH = lseg_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lseg_pkg::job_t wr_job,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output lseg_pkg::job_t rd_job
);
	import lseg_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] fill_q;

	assign full      = (fill_q == CW'(DEPTH));
	assign not_empty = (fill_q != '0);
	assign rd_job    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CW'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("request pushed into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> not_empty)
		else $error("request popped from empty queue");
`endif

endmodule

// ===== src/lseg_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lseg_back
// Frame renderer: per-frame position setup, pixel pipeline, output register.
// ----------------------------------------------------------------------------
module lseg_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        job_valid,
	input  lseg_pkg::job_t              job,
	output logic                        pop,
	input  logic [lseg_pkg::CNT_W-1:0]  n,
	input  logic [23:0]                 color,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [lseg_pkg::IDX_W-1:0]  out_index,
	output logic [23:0]                 out_rgb,
	output logic                        out_last
);
	import lseg_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_RUN  = 3'b100
	} state_t;

	state_t         state_q;
	job_t           job_q;
	logic [2:0]     div_cnt_q;
	logic [6:0]     rem_q;
	logic [6:0]     quo_q;
	logic [6:0]     x_q;
	logic [6:0]     acc_q;
	logic [IDX_W-1:0] idx_q;

	logic           en;
	logic           issue;
	logic           last_px;
	logic [7:0]     trial;
	logic           ge;
	logic [6:0]     acc_sum;
	logic           wrap;

	// pipeline stages
	logic             v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [IDX_W-1:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	logic             last_s1, last_s2, last_s3, last_s4, last_s5;
	logic             scan_s1, scan_s2, scan_s3, scan_s4, scan_s5;
	logic             lit_s1, lit_s2, lit_s3, lit_s4, lit_s5;
	logic [6:0]       x_s1, step_s1;
	logic [12:0]      dd_s2;
	logic [8:0]       w_s3;
	logic [16:0]      p_s4 [3];
	logic [7:0]       c_s5 [3];

	logic [6:0]  d;
	logic [13:0] dd;
	logic [16:0] prod [3];
	logic [30:0] scl  [3];
	logic [7:0]  chan [3];
	logic [23:0] sel_rgb;
	logic        out_valid_q;

	assign en        = !out_valid_q || out_ready;
	assign pop       = (state_q == ST_IDLE) && job_valid;
	assign issue     = (state_q == ST_RUN) && en;
	assign last_px   = ({1'b0, idx_q} + 7'd1) == n;
	assign trial     = {rem_q, SCAN_STEPS[div_cnt_q]};
	assign ge        = trial >= {1'b0, n};
	assign acc_sum   = acc_q + rem_q;
	assign wrap      = acc_sum >= n;
	assign out_valid = out_valid_q;

	always_comb begin
		d  = (x_s1 >= step_s1) ? x_s1 - step_s1 : step_s1 - x_s1;
		dd = d * d;
		chan[0] = color[23:16];
		chan[1] = color[15:8];
		chan[2] = color[7:0];
		for (int k = 0; k < 3; k++) begin
			prod[k] = chan[k] * w_s3;
			scl[k]  = p_s4[k][16:2] * RECIP;
		end
		if (scan_s5) begin
			sel_rgb = {c_s5[0], c_s5[1], c_s5[2]};
		end else if (lit_s5) begin
			sel_rgb = color;
		end else begin
			sel_rgb = '0;
		end
	end

	// Sequencer: divide 70 by n once per frame, then step pixel positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q   <= ST_DIV;
						div_cnt_q <= 3'd6;
					end
				end
				ST_DIV: begin
					if (div_cnt_q == 3'd0) begin
						state_q <= ST_RUN;
					end else begin
						div_cnt_q <= div_cnt_q - 3'd1;
					end
				end
				ST_RUN: begin
					if (issue && last_px) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= job;
			rem_q <= '0;
			quo_q <= '0;
		end
		if (state_q == ST_DIV) begin
			rem_q <= ge ? 7'(trial - {1'b0, n}) : trial[6:0];
			quo_q <= {quo_q[5:0], ge};
			x_q   <= '0;
			acc_q <= '0;
			idx_q <= '0;
		end
		if (issue) begin
			idx_q <= idx_q + IDX_W'(1);
			acc_q <= wrap ? acc_sum - n : acc_sum;
			x_q   <= x_q + quo_q + {6'b0, wrap};
		end
	end

	// Pixel pipeline, advanced as a whole by the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			out_valid_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1  <= idx_q;
			last_s1 <= last_px;
			scan_s1 <= job_q.scan;
			lit_s1  <= job_q.lit;
			x_s1    <= x_q;
			step_s1 <= job_q.step;

			idx_s2  <= idx_s1;
			last_s2 <= last_s1;
			scan_s2 <= scan_s1;
			lit_s2  <= lit_s1;
			dd_s2   <= dd[12:0];

			idx_s3  <= idx_s2;
			last_s3 <= last_s2;
			scan_s3 <= scan_s2;
			lit_s3  <= lit_s2;
			w_s3    <= (dd_s2 < FALLOFF) ? 9'(FALLOFF - dd_s2) : 9'd0;

			idx_s4  <= idx_s3;
			last_s4 <= last_s3;
			scan_s4 <= scan_s3;
			lit_s4  <= lit_s3;
			for (int k = 0; k < 3; k++) begin
				p_s4[k] <= prod[k];
			end

			idx_s5  <= idx_s4;
			last_s5 <= last_s4;
			scan_s5 <= scan_s4;
			lit_s5  <= lit_s4;
			for (int k = 0; k < 3; k++) begin
				c_s5[k] <= scl[k][RECIP_SHIFT+7:RECIP_SHIFT];
			end

			out_index <= idx_s5;
			out_last  <= last_s5;
			out_rgb   <= sel_rgb;
		end
	end

`ifndef SYNTHESIS
	a_pop_divides: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == ST_DIV)
		else $error("frame request taken without starting setup");
	a_div_to_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && div_cnt_q == 3'd0) |=> state_q == ST_RUN)
		else $error("setup finished without starting pixel issue");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (v_s5 == $past(v_s5)))
		else $error("pipeline advanced while output stalled");
`endif

endmodule

// ===== src/led_strip_effect_generator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_strip_effect_generator_core
// Solid, scanner and blink effects for an LED strip, one pixel per request.
// ----------------------------------------------------------------------------
// Each slave request carries one millisecond tick. The front takes one tick
// request per cycle whenever the frame request queue has room, keeps the
// frame timer and effect counter, and queues a frame when one is due. The
// back takes a queued frame, runs a bit-serial divider that sets up the
// pixel spacing 70/N, then issues one pixel per cycle while the master side
// does not stall into a six-stage pipeline (distance, square, falloff,
// channel product, reciprocal scale, output register). A stall on the
// master side holds the whole pixel pipeline; the front keeps taking ticks
// until the queue of frame requests is full.
// ----------------------------------------------------------------------------
module led_strip_effect_generator_core #(
	parameter int MAX_PIXELS  = lseg_pkg::MAX_PIXELS_DEF,
	parameter int QUEUE_DEPTH = lseg_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// tick input: bit 0 tick
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,
	// pixel output: [5:0] pixel_index, [13:6] red, [21:14] green,
	// [29:22] blue, [31:30] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,
	output logic        m_tlast,   // frame_last
	// configuration writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_wdata
);
	import lseg_pkg::*;

	// Configuration registers
	logic [1:0]  mode_q;
	logic [23:0] color_q;
	logic [15:0] interval_q;
	logic [6:0]  count_q;

	logic [CNT_W-1:0] n_eff;
	cfg_evt_t         cfg_evt;
	logic             push;
	logic             full;
	logic             pop;
	logic             job_valid;
	job_t             wr_job;
	job_t             rd_job;
	logic [IDX_W-1:0] px_index;
	logic [23:0]      px_rgb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_SOLID;
			color_q    <= COLOR_RESET;
			interval_q <= INTERVAL_RESET;
			count_q    <= COUNT_RESET;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_EFFECT_MODE:    mode_q     <= cfg_wdata[1:0];
				CFG_MAIN_COLOR:     color_q    <= cfg_wdata;
				CFG_FRAME_INTERVAL: interval_q <= cfg_wdata[15:0];
				CFG_PIXEL_COUNT:    count_q    <= cfg_wdata[6:0];
				default: begin
				end
			endcase
		end
	end

	// A mode write clears the effect counter; solid mode or a new colour
	// needs a redraw on the next tick.
	always_comb begin
		cfg_evt.clear_counter = cfg_we && (cfg_index_t'(cfg_index) == CFG_EFFECT_MODE);
		cfg_evt.set_refresh   = cfg_we &&
			((cfg_index_t'(cfg_index) == CFG_MAIN_COLOR) ||
			 ((cfg_index_t'(cfg_index) == CFG_EFFECT_MODE) &&
			  (cfg_wdata[1:0] == MODE_SOLID)));
	end

	// Clamp the strip length: zero counts as one, cap at MAX_PIXELS
	always_comb begin
		if (count_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (count_q > CNT_W'(MAX_PIXELS)) begin
			n_eff = CNT_W'(MAX_PIXELS);
		end else begin
			n_eff = count_q;
		end
	end

	lseg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (s_tvalid),
		.tick_ready (s_tready),
		.tick       (s_tdata[0]),
		.mode       (mode_q),
		.interval   (interval_q),
		.cfg_evt    (cfg_evt),
		.queue_full (full),
		.push       (push),
		.job        (wr_job)
	);

	lseg_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_job    (wr_job),
		.full      (full),
		.pop       (pop),
		.not_empty (job_valid),
		.rd_job    (rd_job)
	);

	lseg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (rd_job),
		.pop       (pop),
		.n         (n_eff),
		.color     (color_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_index (px_index),
		.out_rgb   (px_rgb),
		.out_last  (m_tlast)
	);

	// Pack the pixel: index lowest, then red, green, blue
	assign m_tdata = {2'b00, px_rgb[7:0], px_rgb[15:8], px_rgb[23:16], px_index};

endmodule

// ===== dv/tb_led_strip_effect_generator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_strip_effect_generator_core
// Self-checking testbench for the LED strip effect generator core.
// ----------------------------------------------------------------------------
// A queue of pending tick requests feeds a clocked driver on the slave side.
// A clocked monitor tracks every accepted tick in a behavioral model of the
// effect engine: frame timer, effect counter, refresh flag, solid, scanner
// and blink drawing. The model pushes the pixels it predicts into a queue.
// Each pixel request on the master side is checked field by field against
// the oldest queued pixel. Register writes happen only while the block is
// idle. A directed opening covers the reset frame, idle ticks, strip length
// limits, every mode and the reserved mode. Random phases with random
// register settings follow, under three idling profiles. One long receiver
// hold-off fills the block so that it stalls its tick input.
// ----------------------------------------------------------------------------
module tb_led_strip_effect_generator_core;
	import lseg_pkg::*;

	localparam int CLK_HALF        = 4;
	localparam int MAX_PIX         = MAX_PIXELS_DEF;
	localparam int RANDOM_TICKS    = 400;
	localparam int DRAIN_CYCLES    = 200;      // full frame latency plus queued jobs
	localparam int PRESSURE_CYCLES = 1500;
	localparam int CYCLE_LIMIT     = 1500000;
	localparam int MAX_REPORTS     = 10;

	// Effect arithmetic of the model
	localparam int unsigned SCAN_TOP    = 70;
	localparam int unsigned SCAN_LEN    = 140;
	localparam int unsigned BLINK_LEN   = 100;
	localparam int unsigned BLINK_DARK  = 50;
	localparam int unsigned FALL        = 500;
	localparam int unsigned ELAPSED_CAP = 131071;

	typedef struct packed {
		logic [5:0] index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} pixel_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;   // bit 0 tick, [7:1] zero
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;          // [5:0] index, [13:6] red, [21:14] green,
	                               // [29:22] blue, [31:30] zero
	logic        m_tlast;          // frame_last
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = CFG_EFFECT_MODE;
	logic [23:0] cfg_wdata = '0;

	bit     tick_q[$];        // tick requests waiting for the driver
	pixel_t pixel_q[$];       // pixels the model expects, oldest first
	logic   tick_taken = 1'b0;
	int     send_idle = 0;
	int     recv_idle = 0;
	int     hold_left = 0;
	int     errors = 0;
	int     cycle_count = 0;

	// Model state and registers
	logic [1:0]  mdl_mode;
	logic [23:0] mdl_color;
	logic [15:0] mdl_interval;
	logic [6:0]  mdl_count;
	int unsigned mdl_elapsed;
	int unsigned mdl_counter;
	bit          mdl_refresh;

	led_strip_effect_generator_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Scanner falloff of one channel
	function automatic logic [7:0] falloff_scale(input logic [7:0] c, input int unsigned w);
		return 8'((c * w) / FALL);
	endfunction

	// Advance the model by one accepted tick request and queue the pixels it draws
	task automatic predict_tick(input logic tick);
		int unsigned n;
		int unsigned cnt;
		int unsigned step;
		int unsigned x;
		int unsigned d;
		int unsigned dd;
		logic [23:0] rgb;
		pixel_t      px;
		if (!tick)
			return;
		if (mdl_elapsed < ELAPSED_CAP)
			mdl_elapsed++;
		if (mdl_mode != MODE_SOLID && mdl_elapsed > mdl_interval) begin
			mdl_refresh = 1'b1;
			mdl_elapsed = 0;
		end
		if (!mdl_refresh)
			return;
		mdl_refresh = 1'b0;
		// Reserved mode consumes the frame but draws nothing
		if (mdl_mode == MODE_RSVD)
			return;
		// Clamp the strip length into 1..MAX_PIX
		n = (mdl_count == 0) ? 1 : (mdl_count > MAX_PIX) ? MAX_PIX : mdl_count;
		cnt = 0;
		step = 0;
		if (mdl_mode == MODE_SCAN) begin
			cnt = mdl_counter % SCAN_LEN;
			step = (cnt > SCAN_TOP) ? SCAN_LEN - cnt : cnt;
		end else if (mdl_mode == MODE_BLINK) begin
			cnt = mdl_counter % BLINK_LEN;
		end
		for (int i = 0; i < n; i++) begin
			rgb = mdl_color;
			if (mdl_mode == MODE_SCAN) begin
				x = (SCAN_TOP * i) / n;
				d = (x >= step) ? x - step : step - x;
				dd = d * d;
				if (dd < FALL)
					rgb = {falloff_scale(mdl_color[23:16], FALL - dd),
						falloff_scale(mdl_color[15:8], FALL - dd),
						falloff_scale(mdl_color[7:0], FALL - dd)};
				else
					rgb = '0;
			end else if (mdl_mode == MODE_BLINK) begin
				rgb = (cnt > BLINK_DARK) ? mdl_color : 24'd0;
			end
			px.index = i[5:0];
			px.red   = rgb[23:16];
			px.green = rgb[15:8];
			px.blue  = rgb[7:0];
			px.last  = (i + 1 == n);
			pixel_q.push_back(px);
		end
		if (mdl_mode != MODE_SOLID)
			mdl_counter = (cnt + 1) & 8'hFF;
	endtask

	task automatic report_mismatch(input string what, input pixel_t want, input pixel_t got);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("mismatch (%s): expected idx %0d rgb %02h%02h%02h last %0b, %s%0d %s%02h%02h%02h %s%0b",
				what, want.index, want.red, want.green, want.blue, want.last,
				"got idx ", got.index, "rgb ", got.red, got.green, got.blue,
				"last ", got.last);
	endtask

	// Write one register while the block is idle and mirror it in the model
	task automatic write_reg(input cfg_index_t idx, input logic [23:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
			CFG_EFFECT_MODE: begin
				mdl_mode = value[1:0];
				if (mdl_mode == MODE_SOLID)
					mdl_refresh = 1'b1;
				mdl_counter = 0;
			end
			CFG_MAIN_COLOR: begin
				mdl_color = value;
				mdl_refresh = 1'b1;
			end
			CFG_FRAME_INTERVAL: mdl_interval = value[15:0];
			CFG_PIXEL_COUNT:    mdl_count = value[6:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_ticks(input int n, input int zero_pct);
		for (int i = 0; i < n; i++)
			tick_q.push_back($urandom_range(99) >= zero_pct);
	endtask

	// Wait until every tick request is taken and every pixel has arrived, then
	// wait DRAIN_CYCLES more so that the block runs empty before the next write
	task automatic settle();
		while (tick_q.size() != 0 || s_tvalid || pixel_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Driver: offer the next tick request at the falling edge once the last
	// one was taken, idling at random
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || tick_taken)) begin
			if (tick_q.size() != 0 && $urandom_range(99) >= send_idle) begin
				s_tdata  <= {7'd0, tick_q.pop_front()};
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: stall at random; a long hold-off counts down here
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// Monitor: predict on accepted ticks, check accepted pixels
	always @(posedge clk) begin
		pixel_t got;
		pixel_t want;
		if (arst_n) begin
			tick_taken <= s_tvalid && s_tready;
			if (m_tvalid && m_tready) begin
				got.index = m_tdata[5:0];
				got.red   = m_tdata[13:6];
				got.green = m_tdata[21:14];
				got.blue  = m_tdata[29:22];
				got.last  = m_tlast;
				if (pixel_q.size() == 0) begin
					report_mismatch("unexpected pixel", '0, got);
				end else begin
					want = pixel_q.pop_front();
					if (got !== want)
						report_mismatch("pixel", want, got);
				end
			end
			if (s_tvalid && s_tready)
				predict_tick(s_tdata[0]);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int  total;
		int  len;
		int  r;
		bit  pressure_done;
		total = 0;
		pressure_done = 0;
		mdl_mode     = MODE_SOLID;
		mdl_color    = COLOR_RESET;
		mdl_interval = INTERVAL_RESET;
		mdl_count    = COUNT_RESET;
		mdl_elapsed  = 0;
		mdl_counter  = 0;
		mdl_refresh  = 1'b1;
		send_idle = 25;
		recv_idle = 86;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset frame on the first tick, idle ticks draw nothing
		tick_q.push_back(1'b0);
		tick_q.push_back(1'b1);
		tick_q.push_back(1'b1);
		tick_q.push_back(1'b0);
		tick_q.push_back(1'b1);
		settle();
		// Black solid frame after a color write
		write_reg(CFG_MAIN_COLOR, 24'h000000);
		tick_q.push_back(1'b1);
		settle();
		// Single-pixel strip, white
		write_reg(CFG_PIXEL_COUNT, 24'd1);
		write_reg(CFG_MAIN_COLOR, 24'hFFFFFF);
		tick_q.push_back(1'b1);
		tick_q.push_back(1'b1);
		settle();
		// Zero length counts as one; a solid mode write refreshes
		write_reg(CFG_PIXEL_COUNT, 24'd0);
		write_reg(CFG_EFFECT_MODE, 24'(MODE_SOLID));
		tick_q.push_back(1'b1);
		settle();
		// Oversize length clamps to the full strip; switching from solid draws at once
		write_reg(CFG_PIXEL_COUNT, 24'd127);
		write_reg(CFG_FRAME_INTERVAL, 24'd0);
		write_reg(CFG_EFFECT_MODE, 24'(MODE_SCAN));
		queue_ticks(3, 0);
		settle();
		write_reg(CFG_FRAME_INTERVAL, 24'd2);
		write_reg(CFG_MAIN_COLOR, 24'h80FF01);
		queue_ticks(4, 0);
		settle();
		// Blink with the longest interval: no frame is due yet
		write_reg(CFG_FRAME_INTERVAL, 24'hFFFF);
		write_reg(CFG_EFFECT_MODE, 24'(MODE_BLINK));
		queue_ticks(2, 0);
		settle();
		// Reserved mode eats frames silently
		write_reg(CFG_FRAME_INTERVAL, 24'd0);
		write_reg(CFG_EFFECT_MODE, 24'(MODE_RSVD));
		queue_ticks(3, 0);
		settle();
		write_reg(CFG_EFFECT_MODE, 24'(MODE_SOLID));
		tick_q.push_back(1'b1);
		settle();

		// Random phases: a third under each idling profile
		while (total < RANDOM_TICKS) begin
			if (total >= 2 * RANDOM_TICKS / 3) begin
				send_idle = 0;
				recv_idle = 0;
			end else if (total >= RANDOM_TICKS / 3) begin
				send_idle = 86;
				recv_idle = 25;
			end
			if (send_idle == 0 && !pressure_done) begin
				// Full-length scanner every tick, receiver held off: fill the block
				write_reg(CFG_PIXEL_COUNT, 24'd64);
				write_reg(CFG_FRAME_INTERVAL, 24'd0);
				write_reg(CFG_EFFECT_MODE, 24'(MODE_SCAN));
				len = 40;
				queue_ticks(len, 0);
				hold_left = PRESSURE_CYCLES;
				pressure_done = 1;
			end else begin
				if ($urandom_range(1)) begin
					r = $urandom_range(9);
					write_reg(CFG_EFFECT_MODE, 24'((r < 2) ? MODE_SOLID :
						(r < 6) ? MODE_SCAN : (r < 9) ? MODE_BLINK : MODE_RSVD));
				end
				if ($urandom_range(1)) begin
					r = $urandom_range(9);
					write_reg(CFG_MAIN_COLOR, (r == 0) ? 24'h000000 :
						(r == 1) ? 24'hFFFFFF : 24'($urandom));
				end
				if ($urandom_range(1)) begin
					r = $urandom_range(9);
					write_reg(CFG_FRAME_INTERVAL, 24'((r < 6) ? $urandom_range(3) :
						(r < 9) ? $urandom_range(30, 4) : $urandom_range(65535)));
				end
				if ($urandom_range(1)) begin
					r = $urandom_range(9);
					// Mostly short strips, now and then full or out of range
					write_reg(CFG_PIXEL_COUNT, 24'((r < 6) ? $urandom_range(12, 1) :
						(r < 8) ? $urandom_range(63, 13) : (r == 8) ? 64 :
						($urandom_range(1) ? 0 : $urandom_range(127, 65))));
				end
				// Long runs let the scanner sweep back and the blink turn on
				if ((mdl_mode == MODE_SCAN || mdl_mode == MODE_BLINK) &&
						mdl_interval == 0 && $urandom_range(2) == 0)
					len = $urandom_range(150, 60);
				else
					len = $urandom_range(40, 10);
				// Stop at the planned number of random ticks
				if (len > RANDOM_TICKS - total)
					len = RANDOM_TICKS - total;
				queue_ticks(len, 10);
			end
			total += len;
			settle();
		end

		if (pixel_q.size() != 0) begin
			errors += pixel_q.size();
			$display("%0d expected pixels never arrived", pixel_q.size());
		end
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== sim.f =====
src/lseg_pkg.sv
src/lseg_front.sv
src/lseg_queue.sv
src/lseg_back.sv
src/led_strip_effect_generator_core.sv
dv/tb_led_strip_effect_generator_core.sv
